>>> hdl/cdt_pkg.sv
// Package for the connection demux table: entry record, widths, codes and the bucket hash.
// No dependencies; used by cdt_cell and connection_demux_table_top.
package cdt_pkg;

	localparam int TABLE_ENTRIES = 64;
	localparam int HASH_BUCKETS  = 32;
	localparam int BKT_W = (HASH_BUCKETS > 1) ? $clog2(HASH_BUCKETS) : 1;
	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int GRP   = 8;
	localparam int NGRP  = (TABLE_ENTRIES + GRP - 1) / GRP;
	localparam int NFLAG = 6;

	localparam logic [2:0] KIND_EXACT    = 3'd0;
	localparam logic [2:0] KIND_ADDRPORT = 3'd1;
	localparam logic [2:0] KIND_PORT     = 3'd2;
	localparam logic [2:0] KIND_ADDR     = 3'd3;
	localparam logic [2:0] KIND_ANY      = 3'd4;

	// Bit 5 of a cell's hit vector is the remove match; bits 0..4 follow the kinds.
	localparam int FLAG_RMV = 5;

	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_REMOVE = 2'd1;
	localparam logic [1:0] CMD_LOOKUP = 2'd2;

	localparam logic [1:0] STAT_DONE  = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_NOENT = 2'd2;

	typedef struct packed {
		logic [2:0]       kind;
		logic [BKT_W-1:0] bucket;
		logic [63:0]      remote_hi;
		logic [63:0]      remote_lo;
		logic [15:0]      remote_port;
		logic [63:0]      local_hi;
		logic [63:0]      local_lo;
		logic [15:0]      local_port;
		logic [9:0]       conn;
	} entry_t;

	// Search key broadcast to every cell, with the bucket of each kind.
	typedef struct packed {
		entry_t               key;
		logic [4:0][BKT_W-1:0] bkt;
	} search_t;

	// Shift control broadcast to every cell.
	typedef struct packed {
		logic             shift_dn;
		logic             shift_up;
		logic [IDX_W-1:0] idx;
	} shift_ctl_t;

	function automatic logic [BKT_W-1:0] bucket_of(input logic [7:0] ra, input logic [15:0] rp,
			input logic [7:0] la, input logic [15:0] lp);
		logic [31:0] x;
		x = {ra, 24'h0} ^ {rp, 16'h0} ^ {16'h0, la, 8'h0} ^ {16'h0, lp};
		return (HASH_BUCKETS > 1) ? x[BKT_W-1:0] : '0;
	endfunction

endpackage

>>> hdl/cdt_cell.sv
// One table slot: holds an entry, shifts with its neighbors and compares against the key.
// Depends on cdt_pkg.
module cdt_cell (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [cdt_pkg::IDX_W-1:0] cell_idx,
	input  cdt_pkg::shift_ctl_t     ctl,
	input  cdt_pkg::search_t        srch,
	input  logic                    up_valid,
	input  cdt_pkg::entry_t         up_entry,
	input  logic                    dn_valid,
	input  cdt_pkg::entry_t         dn_entry,
	output logic                    valid,
	output cdt_pkg::entry_t         entry,
	output logic [cdt_pkg::NFLAG-1:0] hit
);

	logic                        valid_q;
	cdt_pkg::entry_t             entry_q;
	logic [cdt_pkg::NFLAG-1:0]   hit_q;
	logic                        take_up;
	logic                        take_dn;
	logic                        eq_raddr, eq_laddr, eq_lp;
	logic [cdt_pkg::NFLAG-1:0]   hit_d;

	assign take_up = ctl.shift_dn;
	assign take_dn = ctl.shift_up && (cell_idx >= ctl.idx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take_up) begin
			valid_q <= up_valid;
		end else if (take_dn) begin
			valid_q <= dn_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_up) begin
			entry_q <= up_entry;
		end else if (take_dn) begin
			entry_q <= dn_entry;
		end
	end

	always_comb begin
		eq_raddr = (entry_q.remote_hi == srch.key.remote_hi) &&
			(entry_q.remote_lo == srch.key.remote_lo) &&
			(entry_q.remote_port == srch.key.remote_port);
		eq_laddr = (entry_q.local_hi == srch.key.local_hi) &&
			(entry_q.local_lo == srch.key.local_lo);
		eq_lp = entry_q.local_port == srch.key.local_port;
		hit_d[cdt_pkg::KIND_EXACT] = (entry_q.kind == cdt_pkg::KIND_EXACT) &&
			(entry_q.bucket == srch.bkt[0]) && eq_raddr && eq_laddr && eq_lp;
		hit_d[cdt_pkg::KIND_ADDRPORT] = (entry_q.kind == cdt_pkg::KIND_ADDRPORT) &&
			(entry_q.bucket == srch.bkt[1]) && eq_laddr && eq_lp;
		hit_d[cdt_pkg::KIND_PORT] = (entry_q.kind == cdt_pkg::KIND_PORT) &&
			(entry_q.bucket == srch.bkt[2]) && eq_lp;
		hit_d[cdt_pkg::KIND_ADDR] = (entry_q.kind == cdt_pkg::KIND_ADDR) &&
			(entry_q.bucket == srch.bkt[3]) && eq_laddr;
		hit_d[cdt_pkg::KIND_ANY] = (entry_q.kind == cdt_pkg::KIND_ANY) &&
			(entry_q.bucket == srch.bkt[4]);
		hit_d[cdt_pkg::FLAG_RMV] = (entry_q.conn == srch.key.conn) &&
			(entry_q.bucket == srch.bkt[0]);
		if (!valid_q) begin
			hit_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= '0;
		end else begin
			hit_q <= hit_d;
		end
	end

	assign valid = valid_q;
	assign entry = entry_q;
	assign hit   = hit_q;

endmodule

>>> hdl/connection_demux_table_top.sv
// Top level of the connection demux table: handshake, sequencer and hit reduction.
// Depends on cdt_pkg and cdt_cell.
//
//  channel | dir | tdata fields (low bit up)                               | tuser/tlast
//  s_axis  | in  | command, remote_addr_hi, remote_addr_lo, remote_port,   | none
//          |     | local_addr_hi, local_addr_lo, local_port, conn_id       |
//  m_axis  | out | status, found, match_conn, match_kind                   | none
//
// A beat is accepted in idle. The cells then compare in parallel, hits are reduced per
// group of eight cells, and the groups and kinds are resolved, so the result is offered
// from registers in the output state. A beat passes through the states idle, compare,
// group, resolve and output. The table is a row of cells with slot 0 newest; inserts
// shift the row down and removes close the gap by shifting up, at the edge that ends the
// first output cycle.
// Reset clears all valid bits at once; no clearing pass is needed.
// While a result waits on m_axis_tready the block accepts no new beat.
module connection_demux_table_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// command[1:0], remote_addr_hi[65:2], remote_addr_lo[129:66], remote_port[145:130],
	// local_addr_hi[209:146], local_addr_lo[273:210], local_port[289:274], conn_id[299:290]
	input  logic [303:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// status[1:0], found[2], match_conn[12:3], match_kind[15:13]
	output logic [15:0]  m_axis_tdata
);

	localparam int N  = cdt_pkg::TABLE_ENTRIES;
	localparam int NG = cdt_pkg::NGRP;
	localparam int NF = cdt_pkg::NFLAG;

	typedef enum logic [2:0] {ST_IDLE, ST_CMP, ST_GRP, ST_FIN, ST_OUT} state_t;

	state_t                  state_q;
	logic [1:0]              cmd_q;
	cdt_pkg::search_t        srch_q;
	cdt_pkg::shift_ctl_t     ctl_q;
	logic [1:0]              status_q;
	logic                    found_q;
	logic [9:0]              mconn_q;
	logic [2:0]              mkind_q;

	logic [N-1:0]                    cell_valid;
	cdt_pkg::entry_t [N-1:0]         cell_entry;
	logic [N-1:0][NF-1:0]            cell_hit;

	logic [NF-1:0][NG-1:0]                    grp_any_s2;
	logic [NF-1:0][NG-1:0][cdt_pkg::IDX_W-1:0] grp_idx_s2;
	logic [NF-1:0][NG-1:0][9:0]               grp_conn_s2;

	logic [NF-1:0]                    any_f;
	logic [NF-1:0][cdt_pkg::IDX_W-1:0] idx_f;
	logic [NF-1:0][9:0]               conn_f;

	cdt_pkg::entry_t  new_entry;
	logic [63:0]      in_rhi, in_rlo, in_lhi, in_llo;
	logic [15:0]      in_rp, in_lp;

	assign in_rhi = s_axis_tdata[65:2];
	assign in_rlo = s_axis_tdata[129:66];
	assign in_rp  = s_axis_tdata[145:130];
	assign in_lhi = s_axis_tdata[209:146];
	assign in_llo = s_axis_tdata[273:210];
	assign in_lp  = s_axis_tdata[289:274];

	always_comb begin
		new_entry.remote_hi   = in_rhi;
		new_entry.remote_lo   = in_rlo;
		new_entry.remote_port = in_rp;
		new_entry.local_hi    = in_lhi;
		new_entry.local_lo    = in_llo;
		new_entry.local_port  = in_lp;
		new_entry.conn        = s_axis_tdata[299:290];
		new_entry.bucket      = cdt_pkg::bucket_of(in_rlo[7:0], in_rp, in_llo[7:0], in_lp);
		if ((in_rhi | in_rlo) != 64'h0) begin
			new_entry.kind = cdt_pkg::KIND_EXACT;
		end else if ((in_lhi | in_llo) != 64'h0) begin
			new_entry.kind = (in_lp != 16'h0) ? cdt_pkg::KIND_ADDRPORT : cdt_pkg::KIND_ADDR;
		end else begin
			new_entry.kind = (in_lp != 16'h0) ? cdt_pkg::KIND_PORT : cdt_pkg::KIND_ANY;
		end
	end

	// The row of cells. Cell 0 takes the new entry; the last cell refills as empty.
	for (genvar j = 0; j < N; j++) begin : g_cell
		logic            up_v, dn_v;
		cdt_pkg::entry_t up_e, dn_e;
		if (j == 0) begin : g_first
			assign up_v = 1'b1;
			assign up_e = srch_q.key;
		end else begin : g_mid
			assign up_v = cell_valid[j-1];
			assign up_e = cell_entry[j-1];
		end
		if (j == N - 1) begin : g_last
			assign dn_v = 1'b0;
			assign dn_e = cell_entry[j];
		end else begin : g_inner
			assign dn_v = cell_valid[j+1];
			assign dn_e = cell_entry[j+1];
		end
		cdt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_idx (cdt_pkg::IDX_W'(j)),
			.ctl      (ctl_q),
			.srch     (srch_q),
			.up_valid (up_v),
			.up_entry (up_e),
			.dn_valid (dn_v),
			.dn_entry (dn_e),
			.valid    (cell_valid[j]),
			.entry    (cell_entry[j]),
			.hit      (cell_hit[j])
		);
	end

	// First stage of the reduction: the newest hit in each group of eight cells.
	always_ff @(posedge clk) begin
		for (int f = 0; f < NF; f++) begin
			for (int g = 0; g < NG; g++) begin
				grp_any_s2[f][g]  <= 1'b0;
				grp_idx_s2[f][g]  <= '0;
				grp_conn_s2[f][g] <= '0;
				for (int k = cdt_pkg::GRP - 1; k >= 0; k--) begin
					if (g * cdt_pkg::GRP + k < N) begin
						if (cell_hit[g * cdt_pkg::GRP + k][f]) begin
							grp_any_s2[f][g]  <= 1'b1;
							grp_idx_s2[f][g]  <= cdt_pkg::IDX_W'(g * cdt_pkg::GRP + k);
							grp_conn_s2[f][g] <= cell_entry[g * cdt_pkg::GRP + k].conn;
						end
					end
				end
			end
		end
	end

	// Second stage: the newest group with a hit.
	always_comb begin
		for (int f = 0; f < NF; f++) begin
			any_f[f]  = 1'b0;
			idx_f[f]  = '0;
			conn_f[f] = '0;
			for (int g = NG - 1; g >= 0; g--) begin
				if (grp_any_s2[f][g]) begin
					any_f[f]  = 1'b1;
					idx_f[f]  = grp_idx_s2[f][g];
					conn_f[f] = grp_conn_s2[f][g];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ctl_q    <= '0;
			cmd_q    <= cdt_pkg::CMD_INSERT;
			status_q <= cdt_pkg::STAT_DONE;
			found_q  <= 1'b0;
			mconn_q  <= '0;
			mkind_q  <= '0;
		end else begin
			ctl_q.shift_dn <= 1'b0;
			ctl_q.shift_up <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						cmd_q   <= s_axis_tdata[1:0];
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					state_q <= ST_GRP;
				end
				ST_GRP: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					status_q <= cdt_pkg::STAT_DONE;
					found_q  <= 1'b0;
					mconn_q  <= '0;
					mkind_q  <= '0;
					case (cmd_q)
						cdt_pkg::CMD_INSERT: begin
							if (cell_valid[N-1]) begin
								status_q <= cdt_pkg::STAT_FULL;
							end else begin
								ctl_q.shift_dn <= 1'b1;
							end
						end
						cdt_pkg::CMD_REMOVE: begin
							if (any_f[cdt_pkg::FLAG_RMV]) begin
								ctl_q.shift_up <= 1'b1;
								ctl_q.idx      <= idx_f[cdt_pkg::FLAG_RMV];
							end else begin
								status_q <= cdt_pkg::STAT_NOENT;
							end
						end
						cdt_pkg::CMD_LOOKUP: begin
							for (int f = cdt_pkg::FLAG_RMV - 1; f >= 0; f--) begin
								if (any_f[f]) begin
									found_q <= 1'b1;
									mconn_q <= conn_f[f];
									mkind_q <= 3'(f);
								end
							end
						end
						default: begin
						end
					endcase
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (m_axis_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Key and per-kind buckets, captured with the beat.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_axis_tvalid) begin
			srch_q.key    <= new_entry;
			srch_q.bkt[0] <= new_entry.bucket;
			srch_q.bkt[1] <= cdt_pkg::bucket_of(8'h0, 16'h0, in_llo[7:0], in_lp);
			srch_q.bkt[2] <= cdt_pkg::bucket_of(8'h0, 16'h0, 8'h0, in_lp);
			srch_q.bkt[3] <= cdt_pkg::bucket_of(8'h0, 16'h0, in_llo[7:0], 16'h0);
			srch_q.bkt[4] <= cdt_pkg::bucket_of(8'h0, 16'h0, 8'h0, 16'h0);
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = (state_q == ST_OUT);
	assign m_axis_tdata  = {mkind_q, mconn_q, found_q, status_q};

endmodule

>>> test/tb_connection_demux_table_top.sv
// Testbench for connection_demux_table_top: random and directed insert, remove and lookup beats.
// Depends on cdt_pkg and the RTL; a scoreboard class predicts every result beat.
module tb_connection_demux_table_top;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [2:0]  kind;
		logic [4:0]  bucket;
		logic [63:0] rhi, rlo;
		logic [15:0] rp;
		logic [63:0] lhi, llo;
		logic [15:0] lp;
		logic [9:0]  conn;
	} slot_t;

	typedef struct {
		logic [1:0]  cmd;
		logic [63:0] rhi, rlo;
		logic [15:0] rp;
		logic [63:0] lhi, llo;
		logic [15:0] lp;
		logic [9:0]  conn;
	} cmd_t;

	class demux_scoreboard;
		slot_t       table_q[$];
		logic [15:0] pending_q[$];
		int          errors;

		function logic [4:0] hash5(logic [7:0] ra, logic [15:0] rp, logic [7:0] la,
				logic [15:0] lp);
			logic [31:0] x;
			x = ({24'h0, ra} << 24) ^ ({16'h0, rp} << 16) ^ ({24'h0, la} << 8) ^ {16'h0, lp};
			return 5'(x % 32);
		endfunction

		// Scan one kind newest first; returns index or -1.
		function int scan(logic [2:0] kind, logic [4:0] b, cmd_t c);
			bit hit;
			foreach (table_q[i]) begin
				if (table_q[i].kind != kind || table_q[i].bucket != b)
					continue;
				hit = 1;
				if (kind == cdt_pkg::KIND_EXACT)
					hit = table_q[i].rhi == c.rhi && table_q[i].rlo == c.rlo
						&& table_q[i].rp == c.rp;
				if (kind == cdt_pkg::KIND_EXACT || kind == cdt_pkg::KIND_ADDRPORT
						|| kind == cdt_pkg::KIND_ADDR)
					hit = hit && table_q[i].lhi == c.lhi && table_q[i].llo == c.llo;
				if (kind == cdt_pkg::KIND_EXACT || kind == cdt_pkg::KIND_ADDRPORT
						|| kind == cdt_pkg::KIND_PORT)
					hit = hit && table_q[i].lp == c.lp;
				if (hit)
					return i;
			end
			return -1;
		endfunction

		function void note_command(cmd_t c);
			logic [1:0] st;
			logic       fnd;
			logic [9:0] mc;
			logic [2:0] mk;
			slot_t      s;
			logic [4:0] b;
			int         idx;
			st = cdt_pkg::STAT_DONE; fnd = 0; mc = 0; mk = 0;
			b = hash5(c.rlo[7:0], c.rp, c.llo[7:0], c.lp);
			if (c.cmd == cdt_pkg::CMD_INSERT) begin
				if (table_q.size() >= cdt_pkg::TABLE_ENTRIES) begin
					st = cdt_pkg::STAT_FULL;
				end else begin
					if ((c.rhi | c.rlo) != 0) s.kind = cdt_pkg::KIND_EXACT;
					else if ((c.lhi | c.llo) != 0)
						s.kind = c.lp != 0 ? cdt_pkg::KIND_ADDRPORT : cdt_pkg::KIND_ADDR;
					else s.kind = c.lp != 0 ? cdt_pkg::KIND_PORT : cdt_pkg::KIND_ANY;
					s.bucket = b; s.rhi = c.rhi; s.rlo = c.rlo; s.rp = c.rp;
					s.lhi = c.lhi; s.llo = c.llo; s.lp = c.lp; s.conn = c.conn;
					table_q.push_front(s);
				end
			end else if (c.cmd == cdt_pkg::CMD_REMOVE) begin
				st = cdt_pkg::STAT_NOENT;
				foreach (table_q[i]) begin
					if (table_q[i].conn == c.conn && table_q[i].bucket == b) begin
						table_q.delete(i);
						st = cdt_pkg::STAT_DONE;
						break;
					end
				end
			end else if (c.cmd == cdt_pkg::CMD_LOOKUP) begin
				idx = scan(cdt_pkg::KIND_EXACT, b, c);
				mk = cdt_pkg::KIND_EXACT;
				if (idx < 0) begin
					idx = scan(cdt_pkg::KIND_ADDRPORT, hash5(0, 0, c.llo[7:0], c.lp), c);
					mk = cdt_pkg::KIND_ADDRPORT;
				end
				if (idx < 0) begin
					idx = scan(cdt_pkg::KIND_PORT, hash5(0, 0, 0, c.lp), c);
					mk = cdt_pkg::KIND_PORT;
				end
				if (idx < 0) begin
					idx = scan(cdt_pkg::KIND_ADDR, hash5(0, 0, c.llo[7:0], 0), c);
					mk = cdt_pkg::KIND_ADDR;
				end
				if (idx < 0) begin
					idx = scan(cdt_pkg::KIND_ANY, hash5(0, 0, 0, 0), c);
					mk = cdt_pkg::KIND_ANY;
				end
				if (idx >= 0) begin
					fnd = 1;
					mc = table_q[idx].conn;
				end else begin
					mk = 0;
				end
			end
			pending_q.push_back({mk, mc, fnd, st});
		endfunction

		function void check_result(logic [15:0] got);
			logic [15:0] exp;
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected result beat %h", $time, got);
				errors++;
				return;
			end
			exp = pending_q.pop_front();
			if (got[1:0] !== exp[1:0])
				$display("%0t: status expected %0d actual %0d", $time, exp[1:0], got[1:0]);
			if (got[2] !== exp[2])
				$display("%0t: found expected %0d actual %0d", $time, exp[2], got[2]);
			if (got[12:3] !== exp[12:3])
				$display("%0t: match_conn expected %0d actual %0d", $time, exp[12:3], got[12:3]);
			if (got[15:13] !== exp[15:13])
				$display("%0t: match_kind expected %0d actual %0d", $time, exp[15:13], got[15:13]);
			if (got !== exp)
				errors++;
		endfunction
	endclass

	logic         clk = 0;
	logic         arst_n = 0;
	logic         s_axis_tvalid = 0;
	logic         s_axis_tready;
	logic [303:0] s_axis_tdata = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 0;
	logic [15:0]  m_axis_tdata;

	demux_scoreboard sb = new();
	bit  calm;        // no idling in the last part of the run
	bit  hold_off;    // long receiver stall for back pressure
	int  idle_count;
	bit  sending_done;
	cmd_t known_q[$];  // recently inserted keys, reused for removes and lookups

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	connection_demux_table_top DUT (
		.clk, .arst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
		.m_axis_tvalid, .m_axis_tready, .m_axis_tdata
	);

	// Input beats are noted at the accepting edge, results are checked there too.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata);
		if ((arst_n && s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_count <= 0;
		else
			idle_count <= idle_count + 1;
	end

	// Watchdog: fails the run when no beat moves for too long; the limit allows for the long stall.
	always @(posedge clk) begin
		if (idle_count > 2000) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Receiver: random stall bursts unless calm, and a long hold-off when asked.
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off) begin
				m_axis_tready <= 0;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				m_axis_tready <= 0;
				n = $urandom_range(1, 4);
				repeat (n - 1) @(posedge clk);
			end else begin
				m_axis_tready <= 1;
			end
		end
	end

	function automatic logic [63:0] rand64();
		case ($urandom_range(0, 3))
			0: return 64'h0;
			1: return '1;
			2: return {56'h0, 8'($urandom)};
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic logic [15:0] rand16();
		case ($urandom_range(0, 3))
			0: return 16'h0;
			1: return 16'hffff;
			default: return 16'($urandom);
		endcase
	endfunction

	// Offer one beat and hold it until accepted; unless calm, a random gap may come before it.
	task automatic send_beat(cmd_t c);
		int n;
		if (!calm && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 0;
			n = $urandom_range(1, 4);
			repeat (n) @(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= {4'h0, c.conn, c.lp, c.llo, c.lhi, c.rp, c.rlo, c.rhi, c.cmd};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_command(c);
		if (c.cmd == cdt_pkg::CMD_INSERT) begin
			known_q.push_back(c);
			if (known_q.size() > 40) void'(known_q.pop_front());
		end
	endtask

	function automatic cmd_t random_beat();
		cmd_t c;
		int   r;
		c.cmd = 2'($urandom_range(0, 2));
		if ($urandom_range(0, 40) == 0) c.cmd = 2'd3;
		c.rhi = rand64(); c.rlo = rand64(); c.rp = rand16();
		c.lhi = rand64(); c.llo = rand64(); c.lp = rand16();
		c.conn = 10'($urandom);
		// Most removes and lookups reuse an inserted key, perhaps with a wildcard change.
		if (c.cmd != cdt_pkg::CMD_INSERT && known_q.size() > 0 && $urandom_range(0, 4) != 0) begin
			r = c.cmd;
			c = known_q[$urandom_range(0, known_q.size() - 1)];
			c.cmd = 2'(r);
			if (c.cmd == cdt_pkg::CMD_LOOKUP && (c.rhi | c.rlo) == 0) begin
				c.rhi = rand64(); c.rlo = rand64(); c.rp = rand16();
				if (c.llo == 0 && c.lhi == 0) begin
					c.lhi = rand64(); c.llo = rand64();
				end
			end
		end
		// Keep most inserts in wildcard classes so all kinds get hit.
		if (c.cmd == cdt_pkg::CMD_INSERT && $urandom_range(0, 1) == 0) begin
			c.rhi = 0; c.rlo = 0;
			if ($urandom_range(0, 2) == 0) begin
				c.lhi = 0; c.llo = 0;
			end
		end
		return c;
	endfunction

	initial begin
		cmd_t c;
		int   i;
		idle_count = 0;
		calm = 0; hold_off = 0; sending_done = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: one of each kind, lookups that prefer the higher class, misses.
		c = '{cdt_pkg::CMD_LOOKUP, 0, 0, 0, 0, 0, 0, 0};          send_beat(c);
		c = '{cdt_pkg::CMD_REMOVE, 0, 0, 0, 0, 0, 0, 10'h3ff};    send_beat(c);
		c = '{cdt_pkg::CMD_INSERT, 0, 0, 0, 0, 0, 0, 10'd1};      send_beat(c);
		c = '{cdt_pkg::CMD_INSERT, 0, 0, 0, 0, 0, 16'd80, 10'd2}; send_beat(c);
		c = '{cdt_pkg::CMD_INSERT, 0, 0, 0, 64'h1, 64'h2, 0, 10'd3}; send_beat(c);
		c = '{cdt_pkg::CMD_INSERT, 0, 0, 0, 64'h1, 64'h2, 16'd80, 10'd4}; send_beat(c);
		c = '{cdt_pkg::CMD_INSERT, '1, '1, 16'hffff, 64'h1, 64'h2, 16'd80, 10'h3ff};
		send_beat(c);
		c = '{cdt_pkg::CMD_LOOKUP, '1, '1, 16'hffff, 64'h1, 64'h2, 16'd80, 0}; send_beat(c);
		c = '{cdt_pkg::CMD_LOOKUP, 5, 5, 16'd7, 64'h1, 64'h2, 16'd80, 0}; send_beat(c);
		c = '{cdt_pkg::CMD_LOOKUP, 5, 5, 16'd7, 64'h9, 64'h2, 16'd80, 0}; send_beat(c);
		c = '{cdt_pkg::CMD_LOOKUP, 5, 5, 16'd7, 64'h1, 64'h2, 16'd81, 0}; send_beat(c);
		c = '{cdt_pkg::CMD_LOOKUP, 5, 5, 16'd7, '1, '1, 16'd9, 0}; send_beat(c);
		c = '{2'd3, '1, '1, '1, '1, '1, '1, '1}; send_beat(c);
		c = '{cdt_pkg::CMD_REMOVE, '1, '1, 16'hffff, 64'h1, 64'h2, 16'd80, 10'h3ff};
		send_beat(c);
		c = '{cdt_pkg::CMD_REMOVE, 0, 0, 0, 0, 0, 0, 10'd1}; send_beat(c);
		c = '{cdt_pkg::CMD_LOOKUP, 5, 5, 16'd7, '1, '1, 16'd9, 0}; send_beat(c);
		// Fill the table to overflow to reach the full case.
		for (i = 0; i < cdt_pkg::TABLE_ENTRIES + 2; i++) begin
			c = '{cdt_pkg::CMD_INSERT, 0, 0, 0, 0, 64'(i), 16'(i), 10'(i)};
			send_beat(c);
		end

		// Random part; a long receiver hold-off early on stalls the block with a result waiting.
		fork
			begin
				repeat (50) @(posedge clk);
				hold_off = 1;
				repeat (300) @(posedge clk);
				hold_off = 0;
			end
		join_none
		for (i = 0; i < 1250; i++) begin
			if (i == 1000) calm = 1;
			c = random_beat();
			// Drain a crowded table now and then so inserts keep landing.
			if (sb.table_q.size() > 56 && $urandom_range(0, 1) == 0) begin
				c = known_q[$urandom_range(0, known_q.size() - 1)];
				c.cmd = cdt_pkg::CMD_REMOVE;
			end
			send_beat(c);
		end
		s_axis_tvalid <= 0;

		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
